### sv/fjpid_pkg.sv
package fjpid_pkg;

	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_KP_01 = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KP_23 = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KV_01 = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KV_23 = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KI_01 = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_KI_23 = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RATE = 4'd7;

	typedef enum logic [1:0] {
		KIND_TOTAL,
		KIND_PROP,
		KIND_DERIV,
		KIND_INT
	} kind_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_INC,
		MUL_VEL,
		MUL_P,
		MUL_D_LO,
		MUL_D_HI,
		MUL_I_LO,
		MUL_I_HI
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_LOAD,
		ACC_ADD_HI
	} acc_op_t;

	typedef enum logic [2:0] {
		RND_NONE,
		RND_INC,
		RND_P,
		RND_D,
		RND_I
	} rnd_op_t;

	typedef struct packed {
		logic     capture;
		logic     load;
		logic     mag;
		mul_sel_t mul;
		acc_op_t  acc;
		rnd_op_t  rnd;
		logic     vel_load;
		logic     int_upd;
		logic     int_abs;
		logic     commit;
		kind_t    kind;
	} fjpid_cmd_t;

endpackage

### sv/fjpid_ctrl.sv
module fjpid_ctrl #(
	parameter int NUM_JOINTS = 4,
	localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   req_type,
	input  logic                   armed,
	input  logic                   out_stall,
	output logic                   in_stall,
	output logic                   out_valid,
	output fjpid_pkg::fjpid_cmd_t  cmd,
	output logic [JW-1:0]          joint
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_EMIT
	} state_t;

	localparam logic [3:0] ST_LOAD   = 4'd0;
	localparam logic [3:0] ST_MAG    = 4'd1;
	localparam logic [3:0] ST_VEL    = 4'd2;
	localparam logic [3:0] ST_RINC   = 4'd3;
	localparam logic [3:0] ST_INT    = 4'd4;
	localparam logic [3:0] ST_RP     = 4'd5;
	localparam logic [3:0] ST_DHI    = 4'd6;
	localparam logic [3:0] ST_RD     = 4'd7;
	localparam logic [3:0] ST_IHI    = 4'd8;
	localparam logic [3:0] ST_RI     = 4'd9;
	localparam logic [3:0] ST_COMMIT = 4'd10;

	localparam logic [JW-1:0] LAST_J = JW'(NUM_JOINTS - 1);

	state_t           state_q;
	logic [3:0]       step_q;
	logic [JW-1:0]    joint_q;
	fjpid_pkg::kind_t kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= ST_LOAD;
			joint_q <= '0;
			kind_q  <= fjpid_pkg::KIND_TOTAL;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && req_type && armed) begin
						state_q <= S_RUN;
						step_q  <= ST_LOAD;
						joint_q <= '0;
					end
				end
				S_RUN: begin
					if (step_q == ST_COMMIT) begin
						step_q <= ST_LOAD;
						if (joint_q == LAST_J) begin
							state_q <= S_EMIT;
							kind_q  <= fjpid_pkg::KIND_TOTAL;
						end else begin
							joint_q <= JW'(joint_q + 1'b1);
						end
					end else begin
						step_q <= 4'(step_q + 4'd1);
					end
				end
				S_EMIT: begin
					if (!out_stall) begin
						if (kind_q == fjpid_pkg::KIND_INT) begin
							state_q <= S_IDLE;
						end else begin
							kind_q <= fjpid_pkg::kind_t'(2'(kind_q + 2'd1));
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_EMIT);
	assign joint     = joint_q;

	always_comb begin
		cmd         = '0;
		cmd.capture = in_valid && (state_q == S_IDLE);
		cmd.kind    = kind_q;
		if (state_q == S_RUN) begin
			unique case (step_q)
				ST_LOAD: begin
					cmd.load = 1'b1;
				end
				ST_MAG: begin
					cmd.mag = 1'b1;
					cmd.mul = fjpid_pkg::MUL_INC;
				end
				ST_VEL: begin
					cmd.mul = fjpid_pkg::MUL_VEL;
					cmd.acc = fjpid_pkg::ACC_LOAD;
				end
				ST_RINC: begin
					cmd.rnd      = fjpid_pkg::RND_INC;
					cmd.vel_load = 1'b1;
					cmd.mul      = fjpid_pkg::MUL_P;
				end
				ST_INT: begin
					cmd.int_upd = 1'b1;
					cmd.acc     = fjpid_pkg::ACC_LOAD;
					cmd.mul     = fjpid_pkg::MUL_D_LO;
				end
				ST_RP: begin
					cmd.rnd     = fjpid_pkg::RND_P;
					cmd.mul     = fjpid_pkg::MUL_D_HI;
					cmd.acc     = fjpid_pkg::ACC_LOAD;
					cmd.int_abs = 1'b1;
				end
				ST_DHI: begin
					cmd.acc = fjpid_pkg::ACC_ADD_HI;
					cmd.mul = fjpid_pkg::MUL_I_LO;
				end
				ST_RD: begin
					cmd.rnd = fjpid_pkg::RND_D;
					cmd.mul = fjpid_pkg::MUL_I_HI;
					cmd.acc = fjpid_pkg::ACC_LOAD;
				end
				ST_IHI: begin
					cmd.acc = fjpid_pkg::ACC_ADD_HI;
				end
				ST_RI: begin
					cmd.rnd = fjpid_pkg::RND_I;
				end
				ST_COMMIT: begin
					cmd.commit = 1'b1;
				end
				default: begin
					cmd.commit = 1'b0;
				end
			endcase
		end
	end

endmodule

### sv/fjpid_dp.sv
module fjpid_dp #(
	parameter int NUM_JOINTS = 4,
	localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fjpid_pkg::fjpid_cmd_t               cmd,
	input  logic [JW-1:0]                       joint,
	input  logic                                req_type,
	input  logic signed [31:0]                  joint_0,
	input  logic signed [31:0]                  joint_1,
	input  logic signed [31:0]                  joint_2,
	input  logic signed [31:0]                  joint_3,
	input  logic                                cfg_we,
	input  logic [fjpid_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fjpid_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                                armed,
	output logic [1:0]                          action_kind,
	output logic signed [47:0]                  action_0,
	output logic signed [47:0]                  action_1,
	output logic signed [47:0]                  action_2,
	output logic signed [47:0]                  action_3,
	output logic                                last
);

	localparam int NJ_PORTS = 4;
	localparam logic signed [49:0] POS48 = 50'sd140737488355327;
	localparam logic signed [49:0] NEG48 = -50'sd140737488355328;

	function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
		logic signed [47:0] r;
		if (v > POS48) begin
			r = 48'(POS48);
		end else if (v < NEG48) begin
			r = 48'(NEG48);
		end else begin
			r = 48'(v);
		end
		return r;
	endfunction

	logic signed [31:0] joint_in [NJ_PORTS];

	logic        armed_q;
	logic        first_q;
	logic [63:0] kp01_q, kp23_q, kv01_q, kv23_q, ki01_q, ki23_q;
	logic [15:0] ts_q;
	logic [23:0] rate_q;

	logic signed [31:0] ref_q      [NUM_JOINTS];
	logic signed [31:0] prev_pos_q [NUM_JOINTS];
	logic signed [32:0] prev_err_q [NUM_JOINTS];
	logic signed [47:0] integ_q    [NUM_JOINTS];

	logic signed [31:0] pos_q [NUM_JOINTS];
	logic               use_first_q;
	logic signed [32:0] err_q, diff_q;
	logic [31:0]        pe_mag_q, e_mag_q, dif_mag_q;
	logic               pe_neg_q, e_neg_q, dif_neg_q;
	logic [55:0]        vel_mag_q;
	logic [47:0]        int_mag_q;
	logic               int_neg_q;
	logic [63:0]        prod_q;
	logic [87:0]        acc_q;
	logic signed [47:0] inc_q, p_q, dv_q, i_q;
	logic signed [47:0] res_q [NUM_JOINTS][4];

	logic [1:0]         jsel;
	logic [63:0]        kp_w, kv_w, ki_w;
	logic [31:0]        kp_j, kv_j, ki_j;
	logic signed [32:0] ld_err, ld_diff;
	logic signed [32:0] pe_cur;
	logic [31:0]        mul_a, mul_b;
	logic [63:0]        mul_p;
	logic [5:0]         rnd_sh;
	logic               rnd_neg;
	logic [88:0]        rnd_sum, rnd_shf;
	logic [47:0]        rnd_lim, rnd_mag;
	logic signed [47:0] rnd_val;
	logic signed [48:0] int_sum;
	logic signed [49:0] tot_sum;
	logic signed [47:0] act_w [NJ_PORTS];

	assign joint_in[0] = joint_0;
	assign joint_in[1] = joint_1;
	assign joint_in[2] = joint_2;
	assign joint_in[3] = joint_3;

	assign jsel = 2'(joint);
	assign kp_w = jsel[1] ? kp23_q : kp01_q;
	assign kv_w = jsel[1] ? kv23_q : kv01_q;
	assign ki_w = jsel[1] ? ki23_q : ki01_q;
	assign kp_j = jsel[0] ? kp_w[63:32] : kp_w[31:0];
	assign kv_j = jsel[0] ? kv_w[63:32] : kv_w[31:0];
	assign ki_j = jsel[0] ? ki_w[63:32] : ki_w[31:0];

	assign pe_cur  = prev_err_q[joint];
	assign ld_err  = 33'(pos_q[joint]) - 33'(ref_q[joint]);
	assign ld_diff = use_first_q ? 33'sd0 : 33'(pos_q[joint]) - 33'(prev_pos_q[joint]);

	always_comb begin
		unique case (cmd.mul)
			fjpid_pkg::MUL_INC: begin
				mul_a = pe_mag_q;
				mul_b = {16'd0, ts_q};
			end
			fjpid_pkg::MUL_VEL: begin
				mul_a = dif_mag_q;
				mul_b = {8'd0, rate_q};
			end
			fjpid_pkg::MUL_P: begin
				mul_a = e_mag_q;
				mul_b = kp_j;
			end
			fjpid_pkg::MUL_D_LO: begin
				mul_a = vel_mag_q[31:0];
				mul_b = kv_j;
			end
			fjpid_pkg::MUL_D_HI: begin
				mul_a = {8'd0, vel_mag_q[55:32]};
				mul_b = kv_j;
			end
			fjpid_pkg::MUL_I_LO: begin
				mul_a = int_mag_q[31:0];
				mul_b = ki_j;
			end
			fjpid_pkg::MUL_I_HI: begin
				mul_a = {16'd0, int_mag_q[47:32]};
				mul_b = ki_j;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_comb begin
		unique case (cmd.rnd)
			fjpid_pkg::RND_INC: begin
				rnd_sh  = 6'd16;
				rnd_neg = pe_neg_q;
			end
			fjpid_pkg::RND_P: begin
				rnd_sh  = 6'd24;
				rnd_neg = ~e_neg_q;
			end
			fjpid_pkg::RND_D: begin
				rnd_sh  = 6'd32;
				rnd_neg = ~dif_neg_q;
			end
			fjpid_pkg::RND_I: begin
				rnd_sh  = 6'd24;
				rnd_neg = ~int_neg_q;
			end
			default: begin
				rnd_sh  = 6'd16;
				rnd_neg = 1'b0;
			end
		endcase
	end

	assign rnd_sum = {1'b0, acc_q} + (89'd1 << (rnd_sh - 6'd1));
	assign rnd_shf = rnd_sum >> rnd_sh;
	assign rnd_lim = rnd_neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
	assign rnd_mag = (rnd_shf > {41'd0, rnd_lim}) ? rnd_lim : rnd_shf[47:0];
	assign rnd_val = signed'(rnd_neg ? (48'd0 - rnd_mag) : rnd_mag);

	assign int_sum = 49'(integ_q[joint]) + 49'(inc_q);
	assign tot_sum = 50'(p_q) + 50'(dv_q) + 50'(i_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			first_q <= 1'b1;
			kp01_q  <= '0;
			kp23_q  <= '0;
			kv01_q  <= '0;
			kv23_q  <= '0;
			ki01_q  <= '0;
			ki23_q  <= '0;
			ts_q    <= 16'd655;
			rate_q  <= 24'd25600;
			for (int j = 0; j < NUM_JOINTS; j++) begin
				ref_q[j]      <= '0;
				prev_pos_q[j] <= '0;
				prev_err_q[j] <= '0;
				integ_q[j]    <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					fjpid_pkg::REG_KP_01:  kp01_q <= cfg_data;
					fjpid_pkg::REG_KP_23:  kp23_q <= cfg_data;
					fjpid_pkg::REG_KV_01:  kv01_q <= cfg_data;
					fjpid_pkg::REG_KV_23:  kv23_q <= cfg_data;
					fjpid_pkg::REG_KI_01:  ki01_q <= cfg_data;
					fjpid_pkg::REG_KI_23:  ki23_q <= cfg_data;
					fjpid_pkg::REG_PERIOD: ts_q   <= cfg_data[15:0];
					fjpid_pkg::REG_RATE:   rate_q <= cfg_data[23:0];
					default: ;
				endcase
			end
			if (cmd.capture) begin
				if (!req_type) begin
					for (int j = 0; j < NUM_JOINTS; j++) begin
						ref_q[j] <= joint_in[j];
					end
					armed_q <= 1'b1;
				end else if (armed_q) begin
					first_q <= 1'b0;
				end
			end
			if (cmd.load) begin
				prev_pos_q[joint] <= pos_q[joint];
				prev_err_q[joint] <= ld_err;
			end
			if (cmd.int_upd) begin
				integ_q[joint] <= sat48(50'(int_sum));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture && req_type && armed_q) begin
			for (int j = 0; j < NUM_JOINTS; j++) begin
				pos_q[j] <= joint_in[j];
			end
			use_first_q <= first_q;
		end
		if (cmd.load) begin
			err_q    <= ld_err;
			diff_q   <= ld_diff;
			pe_mag_q <= pe_cur[32] ? 32'(33'd0 - pe_cur) : pe_cur[31:0];
			pe_neg_q <= pe_cur[32];
		end
		if (cmd.mag) begin
			e_mag_q   <= err_q[32] ? 32'(33'd0 - err_q) : err_q[31:0];
			e_neg_q   <= err_q[32];
			dif_mag_q <= diff_q[32] ? 32'(33'd0 - diff_q) : diff_q[31:0];
			dif_neg_q <= diff_q[32];
		end
		if (cmd.mul != fjpid_pkg::MUL_NONE) begin
			prod_q <= mul_p;
		end
		unique case (cmd.acc)
			fjpid_pkg::ACC_LOAD:   acc_q <= {24'd0, prod_q};
			fjpid_pkg::ACC_ADD_HI: acc_q <= acc_q + {prod_q[55:0], 32'd0};
			default: ;
		endcase
		if (cmd.vel_load) begin
			vel_mag_q <= prod_q[55:0];
		end
		unique case (cmd.rnd)
			fjpid_pkg::RND_INC: inc_q <= rnd_val;
			fjpid_pkg::RND_P:   p_q   <= rnd_val;
			fjpid_pkg::RND_D:   dv_q  <= rnd_val;
			fjpid_pkg::RND_I:   i_q   <= rnd_val;
			default: ;
		endcase
		if (cmd.int_abs) begin
			int_mag_q <= integ_q[joint][47] ? (48'd0 - integ_q[joint]) : integ_q[joint];
			int_neg_q <= integ_q[joint][47];
		end
		if (cmd.commit) begin
			res_q[joint][fjpid_pkg::KIND_TOTAL] <= sat48(tot_sum);
			res_q[joint][fjpid_pkg::KIND_PROP]  <= p_q;
			res_q[joint][fjpid_pkg::KIND_DERIV] <= dv_q;
			res_q[joint][fjpid_pkg::KIND_INT]   <= i_q;
		end
	end

	for (genvar j = 0; j < NJ_PORTS; j++) begin : g_out
		if (j < NUM_JOINTS) begin : g_on
			assign act_w[j] = res_q[j][cmd.kind];
		end else begin : g_off
			assign act_w[j] = '0;
		end
	end

	assign armed       = armed_q;
	assign action_kind = cmd.kind;
	assign action_0    = act_w[0];
	assign action_1    = act_w[1];
	assign action_2    = act_w[2];
	assign action_3    = act_w[3];
	assign last        = (cmd.kind == fjpid_pkg::KIND_INT);

endmodule

### sv/four_joint_pid_controller.sv
// Reference item: taken while idle, no result beats.
// Position item (loop armed): processed joint by joint on the single shared 32x32 multiplier,
// then four result beats. A new item is not taken until the last result beat has been
// accepted (in_stall is high while busy).
// Reset (arst_n low, asynchronous): gains zero, period 655, rate 25600, loop disarmed,
// integrals and history cleared, next sample treated as the first.
module four_joint_pid_controller #(
	parameter int NUM_JOINTS = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                req_type,
	input  logic signed [31:0]                  joint_0,
	input  logic signed [31:0]                  joint_1,
	input  logic signed [31:0]                  joint_2,
	input  logic signed [31:0]                  joint_3,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          action_kind,
	output logic signed [47:0]                  action_0,
	output logic signed [47:0]                  action_1,
	output logic signed [47:0]                  action_2,
	output logic signed [47:0]                  action_3,
	output logic                                last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fjpid_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fjpid_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

	fjpid_pkg::fjpid_cmd_t cmd;
	logic [JW-1:0]         joint;
	logic                  armed;

	assign cfg_ready = 1'b1;

	fjpid_ctrl #(
		.NUM_JOINTS(NUM_JOINTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.req_type  (req_type),
		.armed     (armed),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd),
		.joint     (joint)
	);

	fjpid_dp #(
		.NUM_JOINTS(NUM_JOINTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.joint       (joint),
		.req_type    (req_type),
		.joint_0     (joint_0),
		.joint_1     (joint_1),
		.joint_2     (joint_2),
		.joint_3     (joint_3),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.armed       (armed),
		.action_kind (action_kind),
		.action_0    (action_0),
		.action_1    (action_1),
		.action_2    (action_2),
		.action_3    (action_3),
		.last        (last)
	);

	a_no_take_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result beats pending");

	a_last_on_integral: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (action_kind == 2'(fjpid_pkg::KIND_INT))))
		else $error("last flag not on integral beat");

	a_kind_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=>
			(out_valid && action_kind == 2'($past(action_kind) + 2'd1)))
		else $error("result beats out of order");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last) |=> !out_valid)
		else $error("beat after end of run");

endmodule
